FILE: rtl/lfu_cache_policy_defines.svh
// Assertion macros for the LFU cache policy block.
// Each macro is empty when SYNTHESIS is defined.
`ifndef LFU_CACHE_POLICY_DEFINES_SVH
`define LFU_CACHE_POLICY_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication: cons must hold whenever ante holds.
`define LFU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define LFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LFU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define LFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/lfu_pkg.sv
package lfu_pkg;

    // Fixed field widths
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int DATA_W  = 32;
    localparam int CAP_W   = 5;

    // Defaults for the top-level parameters
    localparam int ENTRIES_DEF    = 16;
    localparam int COUNT_BITS_DEF = 16;

    // Operation codes
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    // Register file: one 32-bit register per word, paddr[2] is the word index
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_CAPACITY = '0;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

endpackage

FILE: rtl/lfu_ram.sv
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/lfu_cache_policy.sv
// lfu_cache_policy: key-value store with LFU replacement, LRU on count ties.
// Every transaction takes one RAM sweep to match and pick a victim; a hit or
// an eviction adds a second sweep to rerank the entries.
// Requests are taken one at a time, only in idle after the last result is posted.
// Reset (rst_n, async, active low) clears valid bits, occupancy and control.
`include "lfu_cache_policy_defines.svh"

module lfu_cache_policy
    import lfu_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,

    // Request channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic [KEY_W-1:0]   key,
    input  logic [VALUE_W-1:0] value,

    // Result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic               hit,
    output logic [VALUE_W-1:0] read_value,
    output logic               evicted,
    output logic [KEY_W-1:0]   evicted_key,

    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    // capacity reset also restores 16; the entry RAM itself is never cleared.
    // A hit or an eviction takes a second sweep to rerank the entries.

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int RANK_W = IDX_W;
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Entry word layout: {key, value, use count, recency rank}
    localparam int RANK_LSB = 0;
    localparam int CNT_LSB  = RANK_LSB + RANK_W;
    localparam int VAL_LSB  = CNT_LSB + COUNT_BITS;
    localparam int KEY_LSB  = VAL_LSB + VALUE_W;
    localparam int WORD_W   = KEY_LSB + KEY_W;

    localparam logic [CNT_W-1:0]      ENTRIES_C = CNT_W'(ENTRIES);
    localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(ENTRIES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // Sequencer: accept, sweep to match/select, decide, sweep to rerank, post
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_FIX    = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Control state (reset)
    logic               out_valid_reg, out_valid_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic [CAP_W-1:0]   capacity_reg, capacity_next;
    logic [CNT_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic               pipe_vld_reg, pipe_vld_next;
    logic               found_reg, found_next;
    logic               free_have_reg, free_have_next;
    logic               vic_have_reg, vic_have_next;

    // Datapath state (no reset)
    logic                  req_func_reg, req_func_next;
    logic [KEY_W-1:0]      req_key_reg, req_key_next;
    logic [VALUE_W-1:0]    req_value_reg, req_value_next;
    logic [IDX_W-1:0]      pipe_idx_reg, pipe_idx_next;
    logic [IDX_W-1:0]      slot_idx_reg, slot_idx_next;
    logic [COUNT_BITS-1:0] slot_cnt_reg, slot_cnt_next;
    logic [RANK_W-1:0]     slot_rank_reg, slot_rank_next;
    logic [VALUE_W-1:0]    slot_value_reg, slot_value_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]      vic_idx_reg, vic_idx_next;
    logic [COUNT_BITS-1:0] vic_cnt_reg, vic_cnt_next;
    logic [RANK_W-1:0]     vic_rank_reg, vic_rank_next;
    logic [KEY_W-1:0]      vic_key_reg, vic_key_next;
    logic [IDX_W-1:0]      tgt_idx_reg, tgt_idx_next;
    logic [RANK_W-1:0]     base_rank_reg, base_rank_next;
    logic [WORD_W-1:0]     new_word_reg, new_word_next;
    logic                  res_hit_reg, res_hit_next;
    logic [VALUE_W-1:0]    res_rd_reg, res_rd_next;
    logic                  res_ev_reg, res_ev_next;
    logic [KEY_W-1:0]      res_evk_reg, res_evk_next;
    logic                  hit_reg, hit_next;
    logic [VALUE_W-1:0]    read_value_reg, read_value_next;
    logic                  evicted_reg, evicted_next;
    logic [KEY_W-1:0]      evicted_key_reg, evicted_key_next;

    // Entry RAM
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    // Fields of the entry that arrives from the RAM this cycle
    logic [KEY_W-1:0]      rd_key;
    logic [VALUE_W-1:0]    rd_value;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [RANK_W-1:0]     rd_rank;
    logic                  ent_valid;
    logic                  rd_issue;
    logic                  pipe_last;

    // Decision helpers
    logic                  is_put;
    logic                  room;
    logic [CNT_W-1:0]      occ_dec;
    logic [RANK_W-1:0]     top_rank;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  cfg_wr;

    lfu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key    = ram_rdata[KEY_LSB +: KEY_W];
    assign rd_value  = ram_rdata[VAL_LSB +: VALUE_W];
    assign rd_cnt    = ram_rdata[CNT_LSB +: COUNT_BITS];
    assign rd_rank   = ram_rdata[RANK_LSB +: RANK_W];
    assign ent_valid = valid_reg[pipe_idx_reg];

    // Read address walks 0..ENTRIES-1; RAM data for pipe_idx arrives in the cycle after its read
    assign ram_raddr = rd_ptr_reg[IDX_W-1:0];
    assign rd_issue  = (rd_ptr_reg < ENTRIES_C);
    assign pipe_last = pipe_vld_reg && (pipe_idx_reg == LAST_IDX);

    assign is_put   = (req_func_reg == FUNC_PUT);
    // Free slot is usable only below both the programmed capacity and ENTRIES
    assign room     = (CMP_W'(occ_reg) < CMP_W'(capacity_reg)) && (occ_reg < ENTRIES_C);
    assign occ_dec  = occ_reg - CNT_W'(1);
    assign top_rank = occ_dec[RANK_W-1:0];
    assign cnt_inc  = (slot_cnt_reg == COUNT_MAX) ? slot_cnt_reg : slot_cnt_reg + COUNT_ONE;

    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg;
        valid_next       = valid_reg;
        occ_next         = occ_reg;
        capacity_next    = capacity_reg;
        rd_ptr_next      = rd_ptr_reg;
        pipe_vld_next    = pipe_vld_reg;
        found_next       = found_reg;
        free_have_next   = free_have_reg;
        vic_have_next    = vic_have_reg;
        req_func_next    = req_func_reg;
        req_key_next     = req_key_reg;
        req_value_next   = req_value_reg;
        pipe_idx_next    = pipe_idx_reg;
        slot_idx_next    = slot_idx_reg;
        slot_cnt_next    = slot_cnt_reg;
        slot_rank_next   = slot_rank_reg;
        slot_value_next  = slot_value_reg;
        free_idx_next    = free_idx_reg;
        vic_idx_next     = vic_idx_reg;
        vic_cnt_next     = vic_cnt_reg;
        vic_rank_next    = vic_rank_reg;
        vic_key_next     = vic_key_reg;
        tgt_idx_next     = tgt_idx_reg;
        base_rank_next   = base_rank_reg;
        new_word_next    = new_word_reg;
        res_hit_next     = res_hit_reg;
        res_rd_next      = res_rd_reg;
        res_ev_next      = res_ev_reg;
        res_evk_next     = res_evk_reg;
        hit_next         = hit_reg;
        read_value_next  = read_value_reg;
        evicted_next     = evicted_reg;
        evicted_key_next = evicted_key_reg;

        ram_we    = 1'b0;
        ram_waddr = pipe_idx_reg;
        ram_wdata = new_word_reg;

        // Drop the posted result once the consumer takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Capacity write; the user must use the port only while the block is idle (not enforced)
        if (cfg_wr && (paddr[PADDR_W-1:2] == REG_CAPACITY))
        begin
            capacity_next = pwdata[CAP_W-1:0];
        end

        // Shared read stream for both sweeps
        if (state_reg == S_SCAN || state_reg == S_FIX)
        begin
            if (rd_issue)
            begin
                rd_ptr_next   = rd_ptr_reg + CNT_W'(1);
                pipe_vld_next = 1'b1;
                pipe_idx_next = rd_ptr_reg[IDX_W-1:0];
            end
            else
            begin
                pipe_vld_next = 1'b0;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_func_next  = func;
                    req_key_next   = key;
                    req_value_next = value;
                    rd_ptr_next    = '0;
                    pipe_vld_next  = 1'b0;
                    found_next     = 1'b0;
                    free_have_next = 1'b0;
                    vic_have_next  = 1'b0;
                    state_next     = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (pipe_vld_reg)
                begin
                    // Key match
                    if (ent_valid && (rd_key == req_key_reg) && !found_reg)
                    begin
                        found_next      = 1'b1;
                        slot_idx_next   = pipe_idx_reg;
                        slot_cnt_next   = rd_cnt;
                        slot_rank_next  = rd_rank;
                        slot_value_next = rd_value;
                    end
                    // First free slot
                    if (!ent_valid && !free_have_reg)
                    begin
                        free_have_next = 1'b1;
                        free_idx_next  = pipe_idx_reg;
                    end
                    // Victim: lowest count, then lowest rank (least recent)
                    if (ent_valid && (!vic_have_reg || (rd_cnt < vic_cnt_reg) ||
                        ((rd_cnt == vic_cnt_reg) && (rd_rank < vic_rank_reg))))
                    begin
                        vic_have_next = 1'b1;
                        vic_idx_next  = pipe_idx_reg;
                        vic_cnt_next  = rd_cnt;
                        vic_rank_next = rd_rank;
                        vic_key_next  = rd_key;
                    end
                    if (pipe_last)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            S_DECIDE:
            begin
                res_hit_next  = 1'b0;
                res_rd_next   = '0;
                res_ev_next   = 1'b0;
                res_evk_next  = '0;
                rd_ptr_next   = '0;
                pipe_vld_next = 1'b0;
                state_next    = S_DONE;

                if (!is_put)
                begin
                    if (found_reg)
                    begin
                        res_hit_next   = 1'b1;
                        res_rd_next    = slot_value_reg;
                        tgt_idx_next   = slot_idx_reg;
                        base_rank_next = slot_rank_reg;
                        new_word_next  = {req_key_reg, slot_value_reg, cnt_inc, top_rank};
                        state_next     = S_FIX;
                    end
                end
                else if (capacity_reg != '0)
                begin
                    if (found_reg)
                    begin
                        res_hit_next   = 1'b1;
                        tgt_idx_next   = slot_idx_reg;
                        base_rank_next = slot_rank_reg;
                        new_word_next  = {req_key_reg, req_value_reg, cnt_inc, top_rank};
                        state_next     = S_FIX;
                    end
                    else if (room)
                    begin
                        // Fill a free slot as the most recent entry; no rerank needed
                        ram_we     = 1'b1;
                        ram_waddr  = free_idx_reg;
                        ram_wdata  = {req_key_reg, req_value_reg, COUNT_ONE,
                                      occ_reg[RANK_W-1:0]};
                        valid_next[free_idx_reg] = 1'b1;
                        occ_next   = occ_reg + CNT_W'(1);
                    end
                    else
                    begin
                        // Reuse the victim slot in place
                        res_ev_next    = 1'b1;
                        res_evk_next   = vic_key_reg;
                        tgt_idx_next   = vic_idx_reg;
                        base_rank_next = vic_rank_reg;
                        new_word_next  = {req_key_reg, req_value_reg, COUNT_ONE, top_rank};
                        state_next     = S_FIX;
                    end
                end
            end

            S_FIX:
            begin
                if (pipe_vld_reg)
                begin
                    if (pipe_idx_reg == tgt_idx_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = new_word_reg;
                    end
                    else if (ent_valid && (rd_rank > base_rank_reg))
                    begin
                        // Close the gap left by the target in the recency order
                        ram_we    = 1'b1;
                        ram_wdata = {ram_rdata[WORD_W-1:RANK_W], rd_rank - RANK_W'(1)};
                    end
                    if (pipe_last)
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    hit_next         = res_hit_reg;
                    read_value_next  = res_rd_reg;
                    evicted_next     = res_ev_reg;
                    evicted_key_next = res_evk_reg;
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            occ_reg       <= '0;
            capacity_reg  <= CAPACITY_RESET;
            rd_ptr_reg    <= '0;
            pipe_vld_reg  <= 1'b0;
            found_reg     <= 1'b0;
            free_have_reg <= 1'b0;
            vic_have_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
            occ_reg       <= occ_next;
            capacity_reg  <= capacity_next;
            rd_ptr_reg    <= rd_ptr_next;
            pipe_vld_reg  <= pipe_vld_next;
            found_reg     <= found_next;
            free_have_reg <= free_have_next;
            vic_have_reg  <= vic_have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_func_reg    <= req_func_next;
        req_key_reg     <= req_key_next;
        req_value_reg   <= req_value_next;
        pipe_idx_reg    <= pipe_idx_next;
        slot_idx_reg    <= slot_idx_next;
        slot_cnt_reg    <= slot_cnt_next;
        slot_rank_reg   <= slot_rank_next;
        slot_value_reg  <= slot_value_next;
        free_idx_reg    <= free_idx_next;
        vic_idx_reg     <= vic_idx_next;
        vic_cnt_reg     <= vic_cnt_next;
        vic_rank_reg    <= vic_rank_next;
        vic_key_reg     <= vic_key_next;
        tgt_idx_reg     <= tgt_idx_next;
        base_rank_reg   <= base_rank_next;
        new_word_reg    <= new_word_next;
        res_hit_reg     <= res_hit_next;
        res_rd_reg      <= res_rd_next;
        res_ev_reg      <= res_ev_next;
        res_evk_reg     <= res_evk_next;
        hit_reg         <= hit_next;
        read_value_reg  <= read_value_next;
        evicted_reg     <= evicted_next;
        evicted_key_reg <= evicted_key_next;
    end

    // Register read-back
    always_comb
    begin
        unique case (paddr[PADDR_W-1:2])
            REG_CAPACITY: prdata = DATA_W'(capacity_reg);
            default:      prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

    // Occupancy counter tracks the valid bits
    `LFU_ASSERT_SAME(a_occ_matches_valid, clk, rst_n, 1'b1, occ_reg == $countones(valid_reg), "occupancy out of step with valid bits")

    // A fill during the decide step only lands in an empty slot
    `LFU_ASSERT_SAME(a_fill_free_slot, clk, rst_n, (state_reg == S_DECIDE) && ram_we, !valid_reg[ram_waddr], "fill overwrote a valid entry")

    // The rerank sweep rewrites a live entry as its target
    `LFU_ASSERT_SAME(a_fix_target_valid, clk, rst_n, (state_reg == S_FIX) && pipe_vld_reg && (pipe_idx_reg == tgt_idx_reg), valid_reg[tgt_idx_reg], "rerank target is not valid")

    // The rerank sweep runs to its last entry before posting
    `LFU_ASSERT_NEXT(a_fix_runs_out, clk, rst_n, (state_reg == S_FIX) && !pipe_last, state_reg == S_FIX, "rerank sweep left early")

endmodule
